// ===== src/slbe_pkg.sv =====
`timescale 1ns / 1ps

package slbe_pkg;

  localparam logic [1:0] KIND_ECHO      = 2'd0;
  localparam logic [1:0] KIND_LINE_BYTE = 2'd1;
  localparam logic [1:0] KIND_LINE_END  = 2'd2;
  localparam logic [1:0] KIND_NO_LINE   = 2'd3;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic       is_read;
    logic [7:0] data;
  } op_t;

endpackage

// ===== src/serial_line_buffer_with_echo.sv =====
// A command, CR, LF, space, digit or lowercase byte enters a two-entry queue (CR as LF);
// the sequencer takes it when idle. A byte is stored while the ring has room, the last
// slot kept for LF; a read-line request echoes each byte not yet echoed (LF as CR, LF),
// then gives a no-line result if no line is buffered, else the line bytes and an end result.
// The ring memory has one registered read port, so each byte step passes a wait state.
// Reset clears the pointers, counts, queue and output valid; ring contents stay undefined.
`timescale 1ns / 1ps

module serial_line_buffer_with_echo
  import slbe_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic op_valid;
  op_t  op;
  logic op_pop;

  slbe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .command_i (command_i),
    .rx_byte_i (rx_byte_i),
    .op_valid_o(op_valid),
    .op_o      (op),
    .op_pop_i  (op_pop)
  );

  slbe_back #(
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule

// ===== src/slbe_ram.sv =====
`timescale 1ns / 1ps

module slbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/slbe_front.sv =====
`timescale 1ns / 1ps

module slbe_front
  import slbe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic command_i,
  input  logic [7:0] rx_byte_i,
  output logic op_valid_o,
  output op_t  op_o,
  input  logic op_pop_i
);

  op_t        entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       keep;
  logic       push;
  op_t        new_op;

  always_comb begin
    keep = command_i || (rx_byte_i == CHAR_CR) || (rx_byte_i == CHAR_LF) ||
           (rx_byte_i == CHAR_SPACE) ||
           (rx_byte_i >= 8'h30 && rx_byte_i <= 8'h39) ||
           (rx_byte_i >= 8'h61 && rx_byte_i <= 8'h7a);
    new_op.is_read = command_i;
    new_op.data    = (rx_byte_i == CHAR_CR) ? CHAR_LF : rx_byte_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o && keep;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (op_pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !op_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && op_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_op;
    end
  end

endmodule

// ===== src/slbe_back.sv =====
`timescale 1ns / 1ps

module slbe_back
  import slbe_pkg::*;
#(
  parameter int RING_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_valid_i,
  input  op_t        op_i,
  output logic       op_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int CW = PW + 1;
  localparam logic [CW-1:0] DepthW  = CW'(RING_DEPTH);
  localparam logic [CW-1:0] DepthM1 = CW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] DepthM2 = CW'(RING_DEPTH - 2);
  localparam logic [PW-1:0] PtrMax  = PW'(RING_DEPTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ECHK  = 3'd1;
  localparam logic [2:0] ST_EOUT  = 3'd2;
  localparam logic [2:0] ST_LCHK  = 3'd3;
  localparam logic [2:0] ST_LOUT  = 3'd4;
  localparam logic [2:0] ST_LWAIT = 3'd5;
  localparam logic [2:0] ST_LEND  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [PW-1:0] read_ptr_q, read_ptr_d;
  logic [PW-1:0] echo_ptr_q, echo_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] lf_cnt_q, lf_cnt_d;
  logic [CW-1:0] pend_q, pend_d;
  logic          cr_sent_q, cr_sent_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    kind_q, kind_d;
  logic [7:0]    byte_q, byte_d;
  logic          last_q, last_d;
  logic          emit_ok;
  logic          emit;
  logic          wr_en;
  logic [CW-1:0] wr_sum;
  logic [PW-1:0] wr_addr;
  logic [CW-1:0] ahead;
  logic [CW-1:0] pend_new;
  logic [PW-1:0] rd_addr;
  logic [7:0]    rd_data;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PtrMax) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr_sum  = {1'b0, read_ptr_q} + count_q;
    wr_addr = (wr_sum >= DepthW) ? PW'(wr_sum - DepthW) : PW'(wr_sum);
    if (echo_ptr_q >= read_ptr_q) begin
      ahead = {1'b0, echo_ptr_q} - {1'b0, read_ptr_q};
    end else begin
      ahead = {1'b0, echo_ptr_q} + DepthW - {1'b0, read_ptr_q};
    end
    pend_new = (ahead <= count_q) ? count_q - ahead : '0;
    rd_addr  = (state_q == ST_ECHK || state_q == ST_EOUT) ? echo_ptr_q : read_ptr_q;
  end

  slbe_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(op_i.data),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign emit_ok = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    read_ptr_d = read_ptr_q;
    echo_ptr_d = echo_ptr_q;
    count_d    = count_q;
    lf_cnt_d   = lf_cnt_q;
    pend_d     = pend_q;
    cr_sent_d  = cr_sent_q;
    op_pop_o   = 1'b0;
    wr_en      = 1'b0;
    emit       = 1'b0;
    kind_d     = kind_q;
    byte_d     = byte_q;
    last_d     = last_q;
    case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          if (op_i.is_read) begin
            pend_d  = pend_new;
            state_d = ST_ECHK;
          end else if (count_q < DepthM1 &&
                       !(count_q == DepthM2 && op_i.data != CHAR_LF)) begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
            if (op_i.data == CHAR_LF) begin
              lf_cnt_d = lf_cnt_q + CW'(1);
            end
          end
        end
      end
      ST_ECHK: begin
        state_d = (pend_q == '0) ? ST_LCHK : ST_EOUT;
      end
      ST_EOUT: begin
        if (emit_ok) begin
          emit   = 1'b1;
          kind_d = KIND_ECHO;
          last_d = 1'b0;
          if (rd_data == CHAR_LF && !cr_sent_q) begin
            byte_d    = CHAR_CR;
            cr_sent_d = 1'b1;
          end else begin
            byte_d     = rd_data;
            cr_sent_d  = 1'b0;
            echo_ptr_d = ptr_inc(echo_ptr_q);
            pend_d     = pend_q - CW'(1);
            state_d    = ST_ECHK;
          end
        end
      end
      ST_LCHK: begin
        if (lf_cnt_q == '0) begin
          if (emit_ok) begin
            emit    = 1'b1;
            kind_d  = KIND_NO_LINE;
            byte_d  = 8'h00;
            last_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_LOUT;
        end
      end
      ST_LOUT: begin
        if (rd_data == CHAR_LF) begin
          read_ptr_d = ptr_inc(read_ptr_q);
          count_d    = count_q - CW'(1);
          lf_cnt_d   = lf_cnt_q - CW'(1);
          state_d    = ST_LEND;
        end else if (rd_data >= CHAR_SPACE) begin
          if (emit_ok) begin
            emit       = 1'b1;
            kind_d     = KIND_LINE_BYTE;
            byte_d     = rd_data;
            last_d     = 1'b0;
            read_ptr_d = ptr_inc(read_ptr_q);
            count_d    = count_q - CW'(1);
            state_d    = ST_LWAIT;
          end
        end else begin
          read_ptr_d = ptr_inc(read_ptr_q);
          count_d    = count_q - CW'(1);
          state_d    = ST_LWAIT;
        end
      end
      ST_LWAIT: begin
        state_d = ST_LOUT;
      end
      ST_LEND: begin
        if (emit_ok) begin
          emit    = 1'b1;
          kind_d  = KIND_LINE_END;
          byte_d  = 8'h00;
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      read_ptr_q  <= '0;
      echo_ptr_q  <= '0;
      count_q     <= '0;
      lf_cnt_q    <= '0;
      pend_q      <= '0;
      cr_sent_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      read_ptr_q  <= read_ptr_d;
      echo_ptr_q  <= echo_ptr_d;
      count_q     <= count_d;
      lf_cnt_q    <= lf_cnt_d;
      pend_q      <= pend_d;
      cr_sent_q   <= cr_sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

endmodule
